>>> rtl/core/upd_pkg.sv
// Package for the URL percent decoder: payload structs, escape phase codes,
// character constants and hex digit helpers. No dependencies.

package upd_pkg;

    // Character codes
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Default depth of the group queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Most result bytes one input beat can cause
    localparam int GROUP_BYTES = 3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic       final_byte;
    } t_out;

    // Result bytes of one input beat, carried through the queue
    typedef struct packed {
        logic [GROUP_BYTES-1:0][7:0] bytes;
        logic [1:0]                  count;
        logic                        last_grp;
    } t_group;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // True for 0-9, A-F, a-f
    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // Nibble value of a hex digit character
    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c <= 8'h46) begin
            v = c - 8'h37;
        end else begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

>>> rtl/core/upd_front.sv
// Front of the URL percent decoder: tracks the escape phase and turns each
// input beat into a group of zero to three result bytes.
// Depends on upd_pkg.

module upd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  upd_pkg::t_in    i_data,
    output logic            o_push,
    output upd_pkg::t_group o_group
);

    upd_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_held,  n_held;

    logic [7:0] b;
    logic       b_hex;
    logic       b_pct;
    logic       last;

    assign b     = i_data.text_byte;
    assign b_hex = upd_pkg::is_hex(b);
    assign b_pct = (b == upd_pkg::PCT_CHAR);
    assign last  = i_data.end_of_text;

    // Next escape phase and held digit
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        if (i_accept) begin
            n_held = 8'h00;
            case (r_phase)
                upd_pkg::PH_PCT: begin
                    if (b_hex) begin
                        n_phase = upd_pkg::PH_DIGIT;
                        n_held  = b;
                    end else begin
                        n_phase = b_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
                    end
                end
                upd_pkg::PH_DIGIT: begin
                    n_phase = (b_pct && !b_hex) ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = b_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
                end
            endcase
            if (last) begin
                n_phase = upd_pkg::PH_IDLE;
                n_held  = 8'h00;
            end
        end
    end

    // Result group of the current beat
    always_comb begin
        logic [1:0] n;
        logic       do_fresh;
        logic       pend_pct;
        logic       pend_dig;
        n        = 2'd0;
        do_fresh = 1'b0;
        pend_pct = 1'b0;
        pend_dig = 1'b0;
        o_group.bytes    = '0;
        o_group.last_grp = last;
        case (r_phase)
            upd_pkg::PH_PCT: begin
                if (b_hex) begin
                    pend_dig = 1'b1;
                end else begin
                    o_group.bytes[n] = upd_pkg::PCT_CHAR;
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            upd_pkg::PH_DIGIT: begin
                if (b_hex) begin
                    o_group.bytes[n] = {upd_pkg::hex_nib(r_held), upd_pkg::hex_nib(b)};
                    n = n + 2'd1;
                end else begin
                    o_group.bytes[n] = upd_pkg::PCT_CHAR;
                    n = n + 2'd1;
                    o_group.bytes[n] = r_held;
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase
        // Examine the byte afresh
        if (do_fresh) begin
            if (b_pct) begin
                pend_pct = 1'b1;
            end else begin
                o_group.bytes[n] = (b == upd_pkg::PLUS_CHAR) ? upd_pkg::SPACE_CHAR : b;
                n = n + 2'd1;
            end
        end
        // Flush anything held at end of text
        if (last && (pend_pct || pend_dig)) begin
            o_group.bytes[n] = upd_pkg::PCT_CHAR;
            n = n + 2'd1;
            if (pend_dig) begin
                o_group.bytes[n] = b;
                n = n + 2'd1;
            end
        end
        o_group.count = n;
        o_push = i_accept && (n != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_IDLE;
            r_held  <= 8'h00;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

>>> rtl/core/upd_queue.sv
// Short queue of result groups between front and back of the decoder.
// Depends on upd_pkg.

module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  upd_pkg::t_group i_group,
    input  logic            i_pop,
    output upd_pkg::t_group o_head,
    output logic            o_empty,
    output logic            o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    upd_pkg::t_group r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_head  = r_mem[r_rd];

    // Advance pointers and occupancy
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the pushed group
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

endmodule

>>> rtl/core/upd_back.sv
// Back of the URL percent decoder: unpacks queued groups one byte per beat
// into the output register. Depends on upd_pkg.

module upd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  upd_pkg::t_group i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output upd_pkg::t_out   o_out_data
);

    logic          r_valid, n_valid;
    upd_pkg::t_out r_data,  n_data;
    logic [1:0]    r_idx,   n_idx;
    logic          load;
    logic          grp_end;

    assign load    = !i_empty && (!r_valid || i_out_ready);
    assign grp_end = (r_idx == (i_head.count - 2'd1));
    assign o_pop   = load && grp_end;

    // Load the next byte of the head group, advance within it
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_idx   = r_idx;
        if (load) begin
            n_valid             = 1'b1;
            n_data.decoded_byte = i_head.bytes[r_idx];
            n_data.final_byte   = i_head.last_grp && grp_end;
            n_idx               = grp_end ? 2'd0 : r_idx + 2'd1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // Hold the output payload
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

>>> rtl/core/url_percent_decoder.sv
// Top level of the URL percent decoder: front classifier, group queue, back
// unpacker. Depends on upd_pkg, upd_front, upd_queue, upd_back.
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+---------------------------
//   input    | in        | i_in_valid / o_in_ready     | i_in_data  (t_in)
//   output   | out       | o_out_valid / i_out_ready   | o_out_data (t_out)
//
// One input beat is taken per cycle while the group queue has room; its
// results pass through the queue into the output register. The back emits
// one byte per cycle while the output is ready, so a group of two or three
// bytes (broken escape, end-of-text flush) stays at the queue head until its last byte is loaded.
// Reset is synchronous, active low, and clears the escape phase, queue and
// output valid. Output stalls back up through the queue to o_in_ready.

module url_percent_decoder #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  upd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output upd_pkg::t_out o_out_data
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            q_empty;
    logic            q_full;
    upd_pkg::t_group grp;
    upd_pkg::t_group head;

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && !q_full;

    upd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_in_data),
        .o_push   (push),
        .o_group  (grp)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (grp),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> test/url_percent_decoder_tb.sv
// Self-checking testbench for url_percent_decoder: directed and random text
// streams, checked beat by beat against a local decoder model.
// Depends on upd_pkg and the url_percent_decoder RTL.
`timescale 1ns / 100ps

module url_percent_decoder_tb;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          out_ready = 1'b0;
    upd_pkg::t_in  in_data = '0;
    logic          o_in_ready;
    logic          o_out_valid;
    upd_pkg::t_out o_out_data;

    // Raw text waiting to be sent, and decoded characters still due
    upd_pkg::t_in  raw_text_q[$];
    upd_pkg::t_out decoded_q[$];

    // Idle and stall odds, in percent
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // Model state of the escape decoder
    upd_pkg::t_phase esc_phase = upd_pkg::PH_IDLE;
    logic [7:0]      held_char = '0;

    url_percent_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Nibble value of a hex digit character, -1 for anything else
    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int k;
        k = $urandom_range(21);
        if (k < 10) return 8'h30 + k[7:0];
        if (k < 16) return 8'h41 + k[7:0] - 8'd10;
        return 8'h61 + k[7:0] - 8'd16;
    endfunction

    function automatic logic [7:0] rand_non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (hex_digit_value(c) >= 0) c = 8'($urandom_range(255));
        return c;
    endfunction

    task automatic note_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Decode one accepted beat and queue the characters it must produce
    task automatic decode_beat(input upd_pkg::t_in beat);
        logic [7:0] outs[$];
        logic [7:0] c;
        int         nib;
        bit         take_fresh;
        c = beat.text_byte;
        nib = hex_digit_value(c);
        take_fresh = 1'b0;
        case (esc_phase)
            upd_pkg::PH_PCT: begin
                if (nib >= 0) begin
                    held_char = c;
                    esc_phase = upd_pkg::PH_DIGIT;
                end else begin
                    esc_phase = upd_pkg::PH_IDLE;
                    outs.push_back(upd_pkg::PCT_CHAR);
                    take_fresh = 1'b1;
                end
            end
            upd_pkg::PH_DIGIT: begin
                esc_phase = upd_pkg::PH_IDLE;
                if (nib >= 0 && hex_digit_value(held_char) >= 0) begin
                    outs.push_back(8'(hex_digit_value(held_char) * 16 + nib));
                end else begin
                    outs.push_back(upd_pkg::PCT_CHAR);
                    outs.push_back(held_char);
                    take_fresh = 1'b1;
                end
                held_char = '0;
            end
            default: begin
                esc_phase = upd_pkg::PH_IDLE;
                take_fresh = 1'b1;
            end
        endcase
        // Examine the byte as if nothing were held
        if (take_fresh) begin
            if (c == upd_pkg::PCT_CHAR) esc_phase = upd_pkg::PH_PCT;
            else if (c == upd_pkg::PLUS_CHAR) outs.push_back(upd_pkg::SPACE_CHAR);
            else outs.push_back(c);
        end
        // Flush anything held at the end of the string
        if (beat.end_of_text) begin
            if (esc_phase == upd_pkg::PH_PCT) begin
                outs.push_back(upd_pkg::PCT_CHAR);
            end else if (esc_phase == upd_pkg::PH_DIGIT) begin
                outs.push_back(upd_pkg::PCT_CHAR);
                outs.push_back(held_char);
            end
            esc_phase = upd_pkg::PH_IDLE;
            held_char = '0;
        end
        foreach (outs[i]) begin
            decoded_q.push_back(upd_pkg::t_out'{decoded_byte: outs[i],
                final_byte: beat.end_of_text && (i == outs.size() - 1)});
        end
    endtask

    // Driver: hold a beat until it is taken, then offer the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (raw_text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data <= raw_text_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on accepted input beats, check accepted output beats
    always @(posedge i_clk) begin
        upd_pkg::t_out want;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) decode_beat(in_data);
            if (o_out_valid && out_ready) begin
                if (decoded_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat %h/%b",
                        o_out_data.decoded_byte, o_out_data.final_byte));
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_data.decoded_byte !== want.decoded_byte)
                        note_mismatch($sformatf("decoded_byte %h, want %h",
                            o_out_data.decoded_byte, want.decoded_byte));
                    if (o_out_data.final_byte !== want.final_byte)
                        note_mismatch($sformatf("final_byte %b, want %b (byte %h)",
                            o_out_data.final_byte, want.final_byte, want.decoded_byte));
                end
            end
        end
    end

    task automatic add_char(input logic [7:0] c, input logic eot);
        raw_text_q.push_back(upd_pkg::t_in'{text_byte: c, end_of_text: eot});
    endtask

    task automatic add_string(input string s, input logic eot);
        foreach (s[i]) add_char(s[i], eot && (i == s.len() - 1));
    endtask

    // Build one random string of valid escapes, plus signs, plain bytes and some broken escapes
    task automatic add_random_text(output int n_chars);
        logic [7:0] text[$];
        int         n_tokens;
        int         kind;
        n_tokens = $urandom_range(1, 6);
        repeat (n_tokens) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                text.push_back(upd_pkg::PCT_CHAR);
                text.push_back(rand_hex_char());
                text.push_back(rand_hex_char());
            end else if (kind < 50) begin
                text.push_back(upd_pkg::PLUS_CHAR);
            end else if (kind < 60) begin
                text.push_back(upd_pkg::PCT_CHAR);
                text.push_back(rand_non_hex_char());
            end else if (kind < 67) begin
                text.push_back(upd_pkg::PCT_CHAR);
                text.push_back(rand_hex_char());
                text.push_back(rand_non_hex_char());
            end else begin
                text.push_back(8'($urandom_range(255)));
            end
        end
        // Sometimes cut the string inside an escape
        kind = $urandom_range(99);
        if (kind < 8) begin
            text.push_back(upd_pkg::PCT_CHAR);
        end else if (kind < 16) begin
            text.push_back(upd_pkg::PCT_CHAR);
            text.push_back(rand_hex_char());
        end
        foreach (text[i]) add_char(text[i], i == text.size() - 1);
        n_chars = text.size();
    endtask

    // Wait until every beat is sent and every result has come, then settle
    task automatic drain();
        while (raw_text_q.size() > 0 || in_valid || decoded_q.size() > 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int sent;
        int n;
        send_idle_pct <= idle_pct;
        recv_stall_pct <= stall_pct;
        sent = 0;
        while (sent < 30) begin
            add_random_text(n);
            sent += n;
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: escapes of both cases, zero and top byte, plus, broken
        // escapes at both held phases, and end of text with one or two held
        add_string("%41", 1'b0);
        add_string("%6a", 1'b0);
        add_string("%00", 1'b0);
        add_string("%fF", 1'b0);
        add_string("+", 1'b0);
        add_string("%G", 1'b0);
        add_string("%4%", 1'b0);
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b1);
        add_string("%4", 1'b1);
        add_string("%", 1'b1);
        add_string("%+", 1'b1);
        drain();

        // Random phases; each drain doubles as a full sender pause
        run_random_phase(0, 0);
        run_random_phase(85, 0);
        run_random_phase(0, 85);
        run_random_phase(30, 30);

        if (mismatch_count == 0) begin
            $display("** url_percent_decoder: PASSED **");
        end else begin
            $display("** url_percent_decoder: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("** url_percent_decoder: FAILED **");
        $finish;
    end

endmodule
